[hdl/fslm_pkg.sv]
// Shared types, constants and a helper function for the frame slot lease manager.
package fslm_pkg;

  localparam int SLOT_COUNT_DEFAULT = 8;
  localparam int SLOT_W             = 3;
  localparam int TAG_W              = 64;

  typedef enum logic [2:0] {
    OP_ACQ_WRITE = 3'd0,
    OP_PUBLISH   = 3'd1,
    OP_ACQ_READ  = 3'd2,
    OP_REL_READ  = 3'd3,
    OP_ACQ_PAIR  = 3'd4,
    OP_REL_PAIR  = 3'd5
  } op_e;

  typedef struct packed {
    logic [2:0]       operation;
    logic [SLOT_W-1:0] slot_index;
    logic [TAG_W-1:0] sequence_req;
    logic [TAG_W-1:0] capture_time;
    logic             is_unique;
    logic             lease_valid;
  } fslm_in_t;

  typedef struct packed {
    logic              granted;
    logic [SLOT_W-1:0] slot_a;
    logic [SLOT_W-1:0] slot_b;
    logic [TAG_W-1:0]  sequence_a;
    logic [TAG_W-1:0]  sequence_b;
    logic [TAG_W-1:0]  time_a;
    logic [TAG_W-1:0]  time_b;
    logic [TAG_W-1:0]  latest_sequence;
  } fslm_out_t;

  // A protected slot marker: a slot number with a valid bit.
  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] idx;
  } marker_t;

  // One stored entry of the slot memory.
  typedef struct packed {
    logic [TAG_W-1:0] seq_num;
    logic [TAG_W-1:0] capture_time;
  } entry_t;

  // Memory access request issued by the controller for one item.
  typedef struct packed {
    logic              rd_en;
    logic [SLOT_W-1:0] rd_idx_a;
    logic [SLOT_W-1:0] rd_idx_b;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_idx;
    entry_t            wr_entry;
  } mem_req_t;

  // Decision for one item, carried while its memory read completes.
  typedef struct packed {
    logic              granted;
    logic [SLOT_W-1:0] slot_a;
    logic [SLOT_W-1:0] slot_b;
    logic              fill_a;
    logic              fill_b;
    logic [TAG_W-1:0]  latest_sequence;
  } decision_t;

  function automatic logic names(marker_t m, logic [31:0] i);
    return m.valid && (32'(m.idx) == i);
  endfunction

endpackage

[hdl/fslm_slot_mem.sv]
// Slot tag memory: one write port and two registered read ports.
module fslm_slot_mem #(
  parameter int SLOT_COUNT = fslm_pkg::SLOT_COUNT_DEFAULT
) (
  input  logic              clk,
  input  fslm_pkg::mem_req_t req,
  output fslm_pkg::entry_t  rd_a,
  output fslm_pkg::entry_t  rd_b
);
  import fslm_pkg::*;

  localparam int IDX_W = $clog2(SLOT_COUNT);

  entry_t mem [SLOT_COUNT];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[IDX_W'(req.wr_idx)] <= req.wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_a <= mem[IDX_W'(req.rd_idx_a)];
      rd_b <= mem[IDX_W'(req.rd_idx_b)];
    end
  end

endmodule

[hdl/fslm_marker_ctrl.sv]
// Marker registers, free slot search and per-item lease decisions.
module fslm_marker_ctrl #(
  parameter int SLOT_COUNT = fslm_pkg::SLOT_COUNT_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic                 cfg_data,
  input  logic                 accept,
  input  fslm_pkg::fslm_in_t   item,
  output fslm_pkg::mem_req_t   mem_req,
  output fslm_pkg::decision_t  decision
);
  import fslm_pkg::*;

  localparam int IDX_W = $clog2(SLOT_COUNT);

  logic             pool_ready;
  marker_t          latest_slot, reader_slot, unique_newest, unique_older;
  marker_t          pair_older, pair_newer;
  marker_t          latest_slot_next, reader_slot_next;
  marker_t          unique_newest_next, unique_older_next;
  marker_t          pair_older_next, pair_newer_next;
  logic [TAG_W-1:0] latest_seq, latest_seq_next;

  logic [SLOT_COUNT-1:0] prot;
  logic [IDX_W-1:0]      free_idx;
  logic                  pub_ok;

  // Lowest slot that no marker protects; slot 0 when all are taken.
  always_comb begin
    free_idx = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      prot[i] = names(latest_slot, 32'(i)) || names(reader_slot, 32'(i)) ||
                names(unique_newest, 32'(i)) || names(unique_older, 32'(i)) ||
                names(pair_older, 32'(i)) || names(pair_newer, 32'(i));
      if (!prot[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  assign pub_ok = (32'(item.slot_index) < 32'(SLOT_COUNT));

  always_comb begin
    latest_slot_next   = latest_slot;
    reader_slot_next   = reader_slot;
    unique_newest_next = unique_newest;
    unique_older_next  = unique_older;
    pair_older_next    = pair_older;
    pair_newer_next    = pair_newer;
    latest_seq_next    = latest_seq;

    mem_req                       = '0;
    mem_req.wr_idx                = item.slot_index;
    mem_req.wr_entry.seq_num      = item.sequence_req;
    mem_req.wr_entry.capture_time = item.capture_time;
    decision                      = '0;

    unique case (item.operation)
      OP_ACQ_WRITE: begin
        decision.granted = 1'b1;
        decision.slot_a  = free_idx[SLOT_W-1:0];
      end
      OP_PUBLISH: begin
        if (pub_ok) begin
          mem_req.wr_en    = 1'b1;
          latest_slot_next = '{valid: 1'b1, idx: item.slot_index};
          latest_seq_next  = item.sequence_req;
          if (item.is_unique) begin
            unique_older_next  = unique_newest;
            unique_newest_next = '{valid: 1'b1, idx: item.slot_index};
          end
        end
      end
      OP_ACQ_READ: begin
        if (latest_slot.valid && pool_ready) begin
          reader_slot_next = latest_slot;
          decision.granted = 1'b1;
          decision.slot_a  = latest_slot.idx;
          decision.fill_a  = 1'b1;
          mem_req.rd_en    = 1'b1;
          mem_req.rd_idx_a = latest_slot.idx;
        end
      end
      OP_REL_READ: begin
        if (item.lease_valid) begin
          reader_slot_next = '0;
        end
      end
      OP_ACQ_PAIR: begin
        if (unique_older.valid && unique_newest.valid && pool_ready) begin
          pair_older_next  = unique_older;
          pair_newer_next  = unique_newest;
          decision.granted = 1'b1;
          decision.slot_a  = unique_older.idx;
          decision.slot_b  = unique_newest.idx;
          decision.fill_a  = 1'b1;
          decision.fill_b  = 1'b1;
          mem_req.rd_en    = 1'b1;
          mem_req.rd_idx_a = unique_older.idx;
          mem_req.rd_idx_b = unique_newest.idx;
        end
      end
      OP_REL_PAIR: begin
        if (item.lease_valid) begin
          pair_older_next = '0;
          pair_newer_next = '0;
        end
      end
      default: begin
      end
    endcase

    decision.latest_sequence = latest_seq_next;

    if (!accept) begin
      mem_req.rd_en = 1'b0;
      mem_req.wr_en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_ready    <= 1'b0;
      latest_slot   <= '0;
      reader_slot   <= '0;
      unique_newest <= '0;
      unique_older  <= '0;
      pair_older    <= '0;
      pair_newer    <= '0;
      latest_seq    <= '0;
    end else begin
      if (cfg_write) begin
        pool_ready <= cfg_data;
      end
      if (accept) begin
        latest_slot   <= latest_slot_next;
        reader_slot   <= reader_slot_next;
        unique_newest <= unique_newest_next;
        unique_older  <= unique_older_next;
        pair_older    <= pair_older_next;
        pair_newer    <= pair_newer_next;
        latest_seq    <= latest_seq_next;
      end
    end
  end

endmodule

[hdl/frame_slot_lease_manager.sv]
// Top level of the frame slot lease manager: item pipeline and output register.
//
// The block keeps lease bookkeeping for a pool of SLOT_COUNT frame buffer
// slots. Each accepted item is one operation (acquire write, publish, acquire
// read, release read, acquire pair, release pair) and yields exactly one
// result item, in order. The protected markers live in registers and are
// updated at the edge that accepts the item, so the following item already
// sees them. The sequence number and capture tag of every slot live in a
// small synchronous memory with two read ports; a publish writes it at the
// accept edge, and a granted read or pair lease reads it at the same edge
// into the registered read ports. The item's decision waits in stage 1 and
// moves to the output register once that register is free or being emptied,
// so a stall can hold it in stage 1. The block accepts one item every cycle
// as long as results are taken; when the output is stalled it holds at most
// one item waiting on the memory plus the one in the output register. The
// pool_ready register is written with cfg_write and cfg_data and takes
// effect for the next accepted item. Slot numbers on the ports are three
// bits wide, so only slots 0 to 7 can be published; a publish naming a slot
// outside the pool is ignored. There is no clearing pass after reset: the
// memory is only read for slots that a publish has already written.
module frame_slot_lease_manager #(
  parameter int SLOT_COUNT = fslm_pkg::SLOT_COUNT_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic                cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  fslm_pkg::fslm_in_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output fslm_pkg::fslm_out_t out_item
);
  import fslm_pkg::*;

  logic      accept;
  mem_req_t  mem_req;
  decision_t decision;
  entry_t    rd_a, rd_b;

  // Stage 1 holds the decision of an item whose memory read is in flight.
  logic      s1_valid;
  decision_t s1_info;
  logic      s1_move;
  fslm_out_t result;

  // Stage 1 advances whenever the output register is free or being emptied.
  assign s1_move  = !out_valid || out_ready;
  assign in_ready = !s1_valid || s1_move;
  assign accept   = in_valid && in_ready;

  fslm_marker_ctrl #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data),
    .accept   (accept),
    .item     (in_item),
    .mem_req  (mem_req),
    .decision (decision)
  );

  // The read data register only loads on an accepted item, so it holds
  // steady for an item that waits in stage 1.
  fslm_slot_mem #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_mem (
    .clk (clk),
    .req (mem_req),
    .rd_a(rd_a),
    .rd_b(rd_b)
  );

  // Assemble the result; tag fields are zero unless the lease filled them.
  always_comb begin
    result                 = '0;
    result.granted         = s1_info.granted;
    result.slot_a          = s1_info.slot_a;
    result.slot_b          = s1_info.slot_b;
    result.latest_sequence = s1_info.latest_sequence;
    if (s1_info.fill_a) begin
      result.sequence_a = rd_a.seq_num;
      result.time_a     = rd_a.capture_time;
    end
    if (s1_info.fill_b) begin
      result.sequence_b = rd_b.seq_num;
      result.time_b     = rd_b.capture_time;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_info <= decision;
    end
    if (s1_move && s1_valid) begin
      out_item <= result;
    end
  end

  // A publish inside the pool makes its sequence the reported latest one.
  a_publish_latest: assert property (@(posedge clk) disable iff (rst)
    accept && (in_item.operation == OP_PUBLISH) &&
    (32'(in_item.slot_index) < 32'(SLOT_COUNT))
    |=> s1_info.latest_sequence == $past(in_item.sequence_req))
    else $error("publish did not update the latest sequence");

  // An item stalled in stage 1 keeps its memory read data.
  a_stall_holds_read: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_move |=> s1_valid && $stable(rd_a) && $stable(rd_b))
    else $error("read data changed while its item was stalled");

  // A refused or non-lease result carries no slot and no tags.
  a_refused_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.granted
    |-> (out_item.slot_a == '0) && (out_item.slot_b == '0) &&
        (out_item.sequence_a == '0) && (out_item.time_a == '0) &&
        (out_item.sequence_b == '0) && (out_item.time_b == '0))
    else $error("refused result carries slot or tag data");

  // Only a granted pair names a second slot.
  a_slot_b_granted: assert property (@(posedge clk) disable iff (rst)
    s1_valid && (s1_info.slot_b != '0) |-> s1_info.granted && s1_info.fill_b)
    else $error("second slot reported without a granted pair");

endmodule

[test/frame_slot_lease_manager_tb.sv]
// Self-checking testbench for the frame slot lease manager: directed table, random phases.
`timescale 1ns / 100ps

module frame_slot_lease_manager_tb;
  import fslm_pkg::*;

  localparam int SLOTS = SLOT_COUNT_DEFAULT;

  // The package names only the six defined operations; the two spare codes are
  // driven as well, since the block has to treat them as no-ops.
  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;

  localparam logic [TAG_W-1:0] TAG_ONES = '1;

  // Extra settling time after the last result, with a margin.
  localparam int SETTLE_CYCLES   = 4;
  localparam int DRAIN_LIMIT     = 5000;
  localparam int RANDOM_PHASES   = 6;
  localparam int ITEMS_PER_PHASE = 290;

  // Receiver stall patterns.
  localparam int STALL_NONE     = 0;
  localparam int STALL_RANDOM   = 1;
  localparam int STALL_PERIODIC = 2;
  localparam int STALL_LONG     = 3;

  logic      clk;
  logic      rst;
  logic      cfg_write;
  logic      cfg_data;
  logic      in_valid;
  logic      in_ready;
  fslm_in_t  in_item;
  logic      out_valid;
  logic      out_ready;
  fslm_out_t out_item;

  frame_slot_lease_manager #(
    .SLOT_COUNT(SLOTS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  // Our own copy of the lease bookkeeping. It is advanced once per accepted
  // item, in acceptance order, by the sending process.
  marker_t          lease_latest;
  marker_t          lease_reader;
  marker_t          lease_uniq_new;
  marker_t          lease_uniq_old;
  marker_t          lease_pair_old;
  marker_t          lease_pair_new;
  logic [TAG_W-1:0] slot_seq [SLOTS];
  logic [TAG_W-1:0] slot_tag [SLOTS];
  logic             pool_ready_q;

  // Results still owed by the block, oldest first.
  fslm_out_t pending_results[$];

  int          mismatch_count = 0;
  int          stall_mode     = STALL_NONE;
  bit          bursty         = 1'b0;
  int          burst_left     = 0;
  logic [63:0] next_frame_seq;

  // One row of the directed part. A row may ask for a register write before
  // its item; where typed is set the expected result is given in the row
  // itself instead of coming from the predictor.
  typedef struct {
    bit        write_cfg;
    bit        cfg_value;
    fslm_in_t  item;
    bit        typed;
    fslm_out_t result;
  } directed_row_t;

  directed_row_t directed_rows[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic fslm_in_t mk_item(logic [2:0] op, logic [SLOT_W-1:0] slot,
                                       logic [TAG_W-1:0] seq, logic [TAG_W-1:0] tag,
                                       logic uniq, logic lease);
    fslm_in_t it;
    it.operation    = op;
    it.slot_index   = slot;
    it.sequence_req = seq;
    it.capture_time = tag;
    it.is_unique    = uniq;
    it.lease_valid  = lease;
    return it;
  endfunction

  function automatic fslm_out_t mk_result(logic g, logic [SLOT_W-1:0] sa,
                                          logic [SLOT_W-1:0] sb,
                                          logic [TAG_W-1:0] qa, logic [TAG_W-1:0] qb,
                                          logic [TAG_W-1:0] ta, logic [TAG_W-1:0] tb,
                                          logic [TAG_W-1:0] lat);
    fslm_out_t r;
    r.granted         = g;
    r.slot_a          = sa;
    r.slot_b          = sb;
    r.sequence_a      = qa;
    r.sequence_b      = qb;
    r.time_a          = ta;
    r.time_b          = tb;
    r.latest_sequence = lat;
    return r;
  endfunction

  // A slot is withheld from the writer while any of the six markers names it.
  function automatic bit slot_held(int i);
    return (lease_latest.valid   && int'(lease_latest.idx)   == i) ||
           (lease_reader.valid   && int'(lease_reader.idx)   == i) ||
           (lease_uniq_new.valid && int'(lease_uniq_new.idx) == i) ||
           (lease_uniq_old.valid && int'(lease_uniq_old.idx) == i) ||
           (lease_pair_old.valid && int'(lease_pair_old.idx) == i) ||
           (lease_pair_new.valid && int'(lease_pair_new.idx) == i);
  endfunction

  // Lowest unprotected slot; slot 0 when every slot is held.
  function automatic logic [SLOT_W-1:0] lowest_free_slot();
    for (int i = 0; i < SLOTS; i++) begin
      if (!slot_held(i)) return SLOT_W'(i);
    end
    return '0;
  endfunction

  // Applies one operation to the bookkeeping and returns the result it owes.
  // Fields that the operation does not define stay zero.
  function automatic fslm_out_t lease_outcome(fslm_in_t it);
    fslm_out_t r;
    r = '0;
    case (it.operation)
      OP_ACQ_WRITE: begin
        r.granted = 1'b1;
        r.slot_a  = lowest_free_slot();
      end
      OP_PUBLISH: begin
        // A publish onto a protected slot goes through unchecked.
        if (int'(it.slot_index) < SLOTS) begin
          slot_seq[it.slot_index] = it.sequence_req;
          slot_tag[it.slot_index] = it.capture_time;
          lease_latest = '{valid: 1'b1, idx: it.slot_index};
          if (it.is_unique) begin
            lease_uniq_old = lease_uniq_new;
            lease_uniq_new = '{valid: 1'b1, idx: it.slot_index};
          end
        end
      end
      OP_ACQ_READ: begin
        if (lease_latest.valid && pool_ready_q) begin
          lease_reader = lease_latest;
          r.granted    = 1'b1;
          r.slot_a     = lease_latest.idx;
          r.sequence_a = slot_seq[lease_latest.idx];
          r.time_a     = slot_tag[lease_latest.idx];
        end
      end
      OP_REL_READ: begin
        if (it.lease_valid) lease_reader = '0;
      end
      OP_ACQ_PAIR: begin
        if (lease_uniq_old.valid && lease_uniq_new.valid && pool_ready_q) begin
          lease_pair_old = lease_uniq_old;
          lease_pair_new = lease_uniq_new;
          r.granted    = 1'b1;
          r.slot_a     = lease_pair_old.idx;
          r.slot_b     = lease_pair_new.idx;
          r.sequence_a = slot_seq[lease_pair_old.idx];
          r.time_a     = slot_tag[lease_pair_old.idx];
          r.sequence_b = slot_seq[lease_pair_new.idx];
          r.time_b     = slot_tag[lease_pair_new.idx];
        end
      end
      OP_REL_PAIR: begin
        if (it.lease_valid) begin
          lease_pair_old = '0;
          lease_pair_new = '0;
        end
      end
      default: begin
      end
    endcase
    r.latest_sequence = lease_latest.valid ? slot_seq[lease_latest.idx] : '0;
    return r;
  endfunction

  // Tags lean toward the two extremes now and then.
  function automatic logic [TAG_W-1:0] rand_tag();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick == 1) return TAG_ONES;
    return {$urandom, $urandom};
  endfunction

  // Random items mostly follow the normal frame flow: the writer publishes
  // into the slot it would be given, with a running sequence number, and the
  // readers take and drop leases. The rest publishes onto arbitrary (possibly
  // protected) slots, drops stale releases or uses the spare codes.
  function automatic fslm_in_t random_item();
    fslm_in_t it;
    int       pick;
    it = mk_item(3'($urandom_range(0, 7)), SLOT_W'($urandom_range(0, 7)),
                 rand_tag(), rand_tag(), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)));
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      it.operation = pick[0] ? OP_RSVD7 : OP_RSVD6;
    end else if (pick < 20) begin
      it.operation = OP_ACQ_WRITE;
    end else if (pick < 50) begin
      it.operation = OP_PUBLISH;
      if ($urandom_range(0, 3) != 0) it.slot_index = lowest_free_slot();
      if ($urandom_range(0, 4) != 0) begin
        it.sequence_req = next_frame_seq;
        next_frame_seq  = next_frame_seq + 1;
      end
      it.is_unique = ($urandom_range(0, 2) != 0);
    end else if (pick < 65) begin
      it.operation = OP_ACQ_READ;
    end else if (pick < 75) begin
      it.operation   = OP_REL_READ;
      it.lease_valid = ($urandom_range(0, 6) != 0);
    end else if (pick < 88) begin
      it.operation = OP_ACQ_PAIR;
    end else begin
      it.operation   = OP_REL_PAIR;
      it.lease_valid = ($urandom_range(0, 6) != 0);
    end
    return it;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic compare_result(fslm_out_t want, fslm_out_t got);
    check_field("granted", 64'(want.granted), 64'(got.granted));
    check_field("slot_a", 64'(want.slot_a), 64'(got.slot_a));
    check_field("slot_b", 64'(want.slot_b), 64'(got.slot_b));
    check_field("sequence_a", want.sequence_a, got.sequence_a);
    check_field("sequence_b", want.sequence_b, got.sequence_b);
    check_field("time_a", want.time_a, got.time_a);
    check_field("time_b", want.time_b, got.time_b);
    check_field("latest_sequence", want.latest_sequence, got.latest_sequence);
  endtask

  // Presents one item from the falling edge on and holds it until a rising
  // edge sees ready. Valid is left high so that a following item in the same
  // burst goes out back to back.
  task automatic send_item(fslm_in_t it, bit typed, fslm_out_t typed_result);
    fslm_out_t predicted;
    @(negedge clk);
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    predicted = lease_outcome(it);
    pending_results.push_back(typed ? typed_result : predicted);
  endtask

  // Sender gap: valid low, with junk on the payload.
  task automatic idle_gap(int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_valid <= 1'b0;
      in_item  <= mk_item(3'($urandom_range(0, 7)), SLOT_W'($urandom_range(0, 7)),
                          rand_tag(), rand_tag(), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
    end
  endtask

  task automatic paced_send(fslm_in_t it, bit typed, fslm_out_t typed_result);
    if (bursty) begin
      if (burst_left == 0) begin
        idle_gap($urandom_range(1, 6));
        burst_left = $urandom_range(1, 24);
      end
      burst_left--;
    end
    send_item(it, typed, typed_result);
  endtask

  // Stops the sender and waits, with a bound, until every owed result is back
  // and the pipeline has had time to settle.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    for (int w = 0; w < DRAIN_LIMIT && pending_results.size() != 0; w++) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_pool_ready(bit value);
    wait_idle();
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    pool_ready_q = value;
  endtask

  // Receiver: out_ready changes at the falling edge, following the pattern
  // that the current phase selects.
  initial begin : receiver
    int  pat;
    int  hold;
    bit  take;
    pat       = 0;
    hold      = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      case (stall_mode)
        STALL_NONE:     take = 1'b1;
        STALL_RANDOM:   take = ($urandom_range(0, 99) >= 30);
        STALL_PERIODIC: take = ((pat % 5) != 0) && ((pat % 11) != 3);
        default: begin
          if (hold > 0) begin
            hold--;
            take = 1'b0;
          end else if ($urandom_range(0, 19) == 0) begin
            hold = $urandom_range(2, 9);
            take = 1'b0;
          end else begin
            take = 1'b1;
          end
        end
      endcase
      out_ready <= take;
      pat++;
    end
  end

  // Every result taken at a rising edge is matched against the oldest
  // expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with no expectation: expected none, got %h",
                 $time, out_item);
        mismatch_count++;
      end else begin
        compare_result(pending_results.pop_front(), out_item);
      end
    end
  end

  initial begin : stimulus
    fslm_in_t it;
    int       counted;
    bit       noise;

    rst       = 1'b1;
    cfg_write = 1'b0;
    cfg_data  = 1'b0;
    in_valid  = 1'b0;
    in_item   = '0;

    lease_latest   = '0;
    lease_reader   = '0;
    lease_uniq_new = '0;
    lease_uniq_old = '0;
    lease_pair_old = '0;
    lease_pair_new = '0;
    pool_ready_q   = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      slot_seq[i] = '0;
      slot_tag[i] = '0;
    end
    next_frame_seq = {$urandom, $urandom};

    // Directed part. Right after reset nothing is published and the pool is
    // not ready, so every lease is refused and the writer gets slot 0.
    directed_rows.push_back('{1'b1, 1'b0, mk_item(OP_ACQ_WRITE, 3'd5, '0, '0, 1'b1, 1'b1),
                              1'b1, mk_result(1'b1, 3'd0, 3'd0, '0, '0, '0, '0, '0)});
    directed_rows.push_back('{1'b0, 1'b0, mk_item(OP_ACQ_READ, 3'd0, '0, '0, 1'b0, 1'b0),
                              1'b1, '0});
    directed_rows.push_back('{1'b0, 1'b0, mk_item(OP_ACQ_PAIR, 3'd7, TAG_ONES, TAG_ONES,
                              1'b1, 1'b1), 1'b1, '0});
    directed_rows.push_back('{1'b0, 1'b0, mk_item(OP_REL_READ, 3'd0, '0, '0, 1'b0, 1'b1),
                              1'b1, '0});
    directed_rows.push_back('{1'b0, 1'b0, mk_item(OP_REL_PAIR, 3'd0, '0, '0, 1'b0, 1'b1),
                              1'b1, '0});
    // The spare codes do nothing, whatever the other fields say.
    directed_rows.push_back('{1'b0, 1'b0, mk_item(OP_RSVD6, 3'd5, TAG_ONES, TAG_ONES,
                              1'b1, 1'b1), 1'b1, '0});
    directed_rows.push_back('{1'b0, 1'b0, mk_item(OP_RSVD7, 3'd2, TAG_ONES, '0, 1'b1, 1'b0),
                              1'b1, '0});
    // Publish at the top slot with all-ones tags; it becomes latest even
    // though the pool is not ready, but a read is still refused.
    directed_rows.push_back('{1'b0, 1'b0, mk_item(OP_PUBLISH, 3'd7, TAG_ONES, TAG_ONES,
                              1'b1, 1'b0), 1'b1,
                              mk_result(1'b0, 3'd0, 3'd0, '0, '0, '0, '0, TAG_ONES)});
    directed_rows.push_back('{1'b0, 1'b0, mk_item(OP_ACQ_READ, 3'd0, '0, '0, 1'b0, 1'b0),
                              1'b1, mk_result(1'b0, 3'd0, 3'd0, '0, '0, '0, '0, TAG_ONES)});
    // Pool ready: the read is granted, the pair still lacks a second frame.
    directed_rows.push_back('{1'b1, 1'b1, mk_item(OP_ACQ_READ, 3'd3, '0, '0, 1'b1, 1'b1),
                              1'b1, mk_result(1'b1, 3'd7, 3'd0, TAG_ONES, '0, TAG_ONES, '0,
                              TAG_ONES)});
    directed_rows.push_back('{1'b0, 1'b0, mk_item(OP_ACQ_PAIR, 3'd0, '0, '0, 1'b0, 1'b0),
                              1'b1, mk_result(1'b0, 3'd0, 3'd0, '0, '0, '0, '0, TAG_ONES)});
    directed_rows.push_back('{1'b0, 1'b0, mk_item(OP_PUBLISH, 3'd0, '0, '0, 1'b1, 1'b1),
                              1'b1, '0});
    directed_rows.push_back('{1'b0, 1'b0, mk_item(OP_ACQ_PAIR, 3'd0, '0, '0, 1'b0, 1'b0),
                              1'b1, mk_result(1'b1, 3'd7, 3'd0, TAG_ONES, '0, TAG_ONES, '0,
                              '0)});
    // Slots 0 and 7 are held, so the writer gets slot 1.
    directed_rows.push_back('{1'b0, 1'b0, mk_item(OP_ACQ_WRITE, 3'd0, '0, '0, 1'b0, 1'b0),
                              1'b1, mk_result(1'b1, 3'd1, 3'd0, '0, '0, '0, '0, '0)});
    // Releases without a valid lease are ignored.
    directed_rows.push_back('{1'b0, 1'b0, mk_item(OP_REL_PAIR, 3'd0, '0, '0, 1'b0, 1'b0),
                              1'b0, '0});
    directed_rows.push_back('{1'b0, 1'b0, mk_item(OP_REL_READ, 3'd0, '0, '0, 1'b0, 1'b0),
                              1'b0, '0});
    // Build up six distinct protected slots, then a publish onto a held one.
    directed_rows.push_back('{1'b0, 1'b0, mk_item(OP_PUBLISH, 3'd3, 64'h3, 64'h1003, 1'b1,
                              1'b0), 1'b0, '0});
    directed_rows.push_back('{1'b0, 1'b0, mk_item(OP_PUBLISH, 3'd4, 64'h4, 64'h1004, 1'b1,
                              1'b0), 1'b0, '0});
    directed_rows.push_back('{1'b0, 1'b0, mk_item(OP_ACQ_PAIR, 3'd0, '0, '0, 1'b0, 1'b0),
                              1'b0, '0});
    directed_rows.push_back('{1'b0, 1'b0, mk_item(OP_PUBLISH, 3'd5, 64'h5, 64'h1005, 1'b1,
                              1'b0), 1'b0, '0});
    directed_rows.push_back('{1'b0, 1'b0, mk_item(OP_PUBLISH, 3'd6, 64'h6, 64'h1006, 1'b1,
                              1'b0), 1'b0, '0});
    directed_rows.push_back('{1'b0, 1'b0, mk_item(OP_PUBLISH, 3'd2, 64'h2, 64'h1002, 1'b0,
                              1'b0), 1'b0, '0});
    directed_rows.push_back('{1'b0, 1'b0, mk_item(OP_ACQ_READ, 3'd0, '0, '0, 1'b0, 1'b0),
                              1'b0, '0});
    directed_rows.push_back('{1'b0, 1'b0, mk_item(OP_PUBLISH, 3'd1, 64'h1, 64'h1001, 1'b0,
                              1'b0), 1'b0, '0});
    directed_rows.push_back('{1'b0, 1'b0, mk_item(OP_ACQ_WRITE, 3'd0, '0, '0, 1'b0, 1'b0),
                              1'b0, '0});
    directed_rows.push_back('{1'b0, 1'b0, mk_item(OP_PUBLISH, 3'd3, 64'h33, 64'h2003, 1'b0,
                              1'b0), 1'b0, '0});
    directed_rows.push_back('{1'b0, 1'b0, mk_item(OP_REL_READ, 3'd0, '0, '0, 1'b0, 1'b1),
                              1'b0, '0});
    directed_rows.push_back('{1'b0, 1'b0, mk_item(OP_ACQ_WRITE, 3'd0, '0, '0, 1'b0, 1'b0),
                              1'b0, '0});

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    stall_mode = STALL_RANDOM;
    bursty     = 1'b1;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].write_cfg) set_pool_ready(directed_rows[i].cfg_value);
      paced_send(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].result);
    end

    // Random phases. The first runs with no idling on either side; the pool
    // goes down in two of them so that leases are refused for a while.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      set_pool_ready(!(phase == 1 || phase == 4));
      stall_mode = phase % 4;
      bursty     = (phase != 0);
      burst_left = 0;
      counted    = 0;
      while (counted < ITEMS_PER_PHASE) begin
        it = random_item();
        paced_send(it, 1'b0, '0);
        noise = (it.operation == OP_RSVD6) || (it.operation == OP_RSVD7) ||
                (((it.operation == OP_REL_READ) || (it.operation == OP_REL_PAIR)) &&
                 !it.lease_valid);
        if (!noise) counted++;
      end
    end

    wait_idle();
    if (pending_results.size() != 0) begin
      $display("%0t: %0d results never arrived: expected %h, got none", $time,
               pending_results.size(), pending_results[0]);
      mismatch_count += pending_results.size();
    end

    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Far beyond the slowest legal run of about two thousand items.
  initial begin : watchdog
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

[frame_slot_lease_manager.f]
hdl/fslm_pkg.sv
hdl/fslm_slot_mem.sv
hdl/fslm_marker_ctrl.sv
hdl/frame_slot_lease_manager.sv
test/frame_slot_lease_manager_tb.sv
